// File: rtl/cbb_pkg.sv
// shared types and constants for the circular byte buffer
`timescale 1ns / 1ps

package cbb_pkg;

	// default geometry
	localparam int DEPTH_DEF  = 1024;
	localparam int BURST_DEF  = 8;
	localparam int SIZE_RESET = 1024;

	// field widths
	localparam int CFG_W   = 11;
	localparam int TYPE_W  = 3;
	localparam int DATA_W  = 64;
	localparam int COUNT_W = 4;
	localparam int OFFS_W  = 10;
	localparam int STAT_W  = 10;

	// request types
	localparam logic [TYPE_W-1:0] REQ_WRITE = 3'd0;
	localparam logic [TYPE_W-1:0] REQ_READ  = 3'd1;
	localparam logic [TYPE_W-1:0] REQ_PEEK  = 3'd2;
	localparam logic [TYPE_W-1:0] REQ_FLUSH = 3'd3;
	localparam logic [TYPE_W-1:0] REQ_MATCH = 3'd4;

	// pattern byte that matches anything
	localparam logic [7:0] WILDCARD = 8'h3F;

	// byte store access controls
	typedef struct packed {
		logic en;
		logic we;
	} mem_ctl_t;

	// sequencer status
	typedef struct packed {
		logic busy;
		logic ovf;
		logic rd_pend;
	} stat_t;

endpackage

// File: rtl/cbb_store.sv
// single-port byte store with registered read data
`timescale 1ns / 1ps

module cbb_store #(
	parameter int DEPTH = cbb_pkg::DEPTH_DEF,
	parameter int PTR_W = $clog2(DEPTH)
) (
	input  logic             clk,
	input  cbb_pkg::mem_ctl_t mem_ctl,
	input  logic [PTR_W-1:0] addr,
	input  logic [7:0]       wdata,
	output logic [7:0]       rdata
);

	logic [7:0] mem [DEPTH];

	// one access per cycle, write or read
	always_ff @(posedge clk) begin
		if (mem_ctl.en) begin
			if (mem_ctl.we) begin
				mem[addr] <= wdata;
			end else begin
				rdata <= mem[addr];
			end
		end
	end

endmodule

// File: rtl/cbb_ctrl.sv
// request sequencer: pointers, byte walk over the store and result register
`timescale 1ns / 1ps

module cbb_ctrl #(
	parameter int DEPTH = cbb_pkg::DEPTH_DEF,
	parameter int BURST = cbb_pkg::BURST_DEF,
	parameter int PTR_W = $clog2(DEPTH)
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_we,
	input  logic [cbb_pkg::CFG_W-1:0]    cfg_wdata,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic [cbb_pkg::TYPE_W-1:0]   in_type,
	input  logic [cbb_pkg::DATA_W-1:0]   in_data,
	input  logic [cbb_pkg::COUNT_W-1:0]  in_count,
	input  logic [cbb_pkg::OFFS_W-1:0]   in_offset,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [cbb_pkg::DATA_W-1:0]   read_data,
	output logic [cbb_pkg::COUNT_W-1:0]  done_count,
	output logic                         matched,
	output logic [cbb_pkg::STAT_W-1:0]   used_count,
	output logic [cbb_pkg::STAT_W-1:0]   free_count,
	output logic                         overflow,
	output cbb_pkg::mem_ctl_t            mem_ctl,
	output logic [PTR_W-1:0]             mem_addr,
	output logic [7:0]                   mem_wdata,
	input  logic [7:0]                   mem_rdata,
	output cbb_pkg::stat_t               stat
);

	localparam int SIZE_W   = PTR_W + 1;
	localparam int SUM_W    = ((PTR_W > cbb_pkg::OFFS_W) ? PTR_W : cbb_pkg::OFFS_W) + 1;
	localparam int RST_SIZE = (cbb_pkg::SIZE_RESET > DEPTH) ? DEPTH : cbb_pkg::SIZE_RESET;

	localparam logic [1:0] ST_IDLE   = 2'd0;
	localparam logic [1:0] ST_DECODE = 2'd1;
	localparam logic [1:0] ST_RUN    = 2'd2;
	localparam logic [1:0] ST_FINISH = 2'd3;

	logic [1:0]        state_q;
	logic [PTR_W-1:0]  wp_q, rp_q, used_q;
	logic [SIZE_W-1:0] size_q;
	logic              ovf_q;

	logic [cbb_pkg::TYPE_W-1:0]  type_q;
	logic [cbb_pkg::DATA_W-1:0]  data_q;
	logic [cbb_pkg::COUNT_W-1:0] n_q, cnt_q, k_q;
	logic [cbb_pkg::OFFS_W-1:0]  offs_q;
	logic [PTR_W-1:0]            addr_q;
	logic [cbb_pkg::DATA_W-1:0]  rdata_q;
	logic                        ok_q, refuse_q;
	logic                        rd_s1;
	logic [2:0]                  k_s1;
	logic                        out_valid_q;

	logic [SIZE_W-1:0] size_clamp, free_w, addr_inc;
	logic [PTR_W-1:0]  addr_adv, used_nxt;
	logic [SUM_W-1:0]  avail_w, psum, pwrap;
	logic              n_le_free, n_le_used, n_le_avail;
	logic              issue, finish_go, hit;
	logic [7:0]        pat;
	logic [cbb_pkg::COUNT_W-1:0] n_clamp;

	// size register value from a configuration write
	always_comb begin
		if (cfg_wdata < cbb_pkg::CFG_W'(2)) begin
			size_clamp = SIZE_W'(2);
		end else if (32'(cfg_wdata) > 32'(DEPTH)) begin
			size_clamp = SIZE_W'(DEPTH);
		end else begin
			size_clamp = SIZE_W'(cfg_wdata);
		end
	end

	// burst length limit
	assign n_clamp = (32'(in_count) > 32'(BURST)) ? cbb_pkg::COUNT_W'(BURST) : in_count;

	// decode arithmetic on held state
	assign free_w     = size_q - SIZE_W'(1) - SIZE_W'(used_q);
	assign n_le_free  = 32'(n_q) <= 32'(free_w);
	assign n_le_used  = 32'(n_q) <= 32'(used_q);
	assign avail_w    = (SUM_W'(offs_q) < SUM_W'(used_q)) ? SUM_W'(used_q) - SUM_W'(offs_q)
	                                                       : '0;
	assign n_le_avail = SUM_W'(n_q) <= avail_w;
	assign psum       = SUM_W'(rp_q) + SUM_W'(offs_q);
	assign pwrap      = (psum >= SUM_W'(size_q)) ? psum - SUM_W'(size_q) : psum;

	// next slot with wrap at the buffer size
	assign addr_inc = SIZE_W'(addr_q) + SIZE_W'(1);
	assign addr_adv = (addr_inc == size_q) ? '0 : PTR_W'(addr_inc);

	// store access
	assign issue          = (state_q == ST_RUN) && (k_q != cnt_q);
	assign mem_ctl.en     = issue;
	assign mem_ctl.we     = (type_q == cbb_pkg::REQ_WRITE);
	assign mem_addr       = addr_q;
	assign mem_wdata      = data_q[8*k_q[2:0] +: 8];
	assign pat            = data_q[8*k_s1 +: 8];

	// completion
	assign finish_go = (state_q == ST_FINISH) && (!out_valid_q || out_ready);
	assign hit       = (type_q == cbb_pkg::REQ_MATCH) && (cnt_q != '0) && ok_q;

	always_comb begin
		case (type_q)
			cbb_pkg::REQ_WRITE: used_nxt = used_q + PTR_W'(cnt_q);
			cbb_pkg::REQ_READ:  used_nxt = used_q - PTR_W'(cnt_q);
			cbb_pkg::REQ_MATCH: used_nxt = hit ? used_q - PTR_W'(cnt_q) : used_q;
			cbb_pkg::REQ_FLUSH: used_nxt = '0;
			default:            used_nxt = used_q;
		endcase
	end

	// sequencer and buffer state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			wp_q    <= '0;
			rp_q    <= '0;
			used_q  <= '0;
			size_q  <= SIZE_W'(RST_SIZE);
			ovf_q   <= 1'b0;
			rd_s1   <= 1'b0;
		end else begin
			rd_s1 <= issue && (type_q != cbb_pkg::REQ_WRITE);
			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						state_q <= ST_DECODE;
					end
				end
				ST_DECODE: begin
					state_q <= ST_RUN;
				end
				ST_RUN: begin
					if (!issue) begin
						state_q <= ST_FINISH;
					end
				end
				ST_FINISH: begin
					if (finish_go) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
			// size change empties the buffer
			if (cfg_we) begin
				size_q <= size_clamp;
				wp_q   <= '0;
				rp_q   <= '0;
				used_q <= '0;
			end else if (finish_go) begin
				used_q <= used_nxt;
				if (refuse_q) begin
					ovf_q <= 1'b1;
				end
				case (type_q)
					cbb_pkg::REQ_WRITE: wp_q <= addr_q;
					cbb_pkg::REQ_READ:  rp_q <= addr_q;
					cbb_pkg::REQ_MATCH: begin
						if (hit) begin
							rp_q <= addr_q;
						end
					end
					cbb_pkg::REQ_FLUSH: rp_q <= wp_q;
					default: ;
				endcase
			end
		end
	end

	// per-request working registers
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && in_valid) begin
			type_q <= in_type;
			data_q <= in_data;
			n_q    <= n_clamp;
			offs_q <= in_offset;
		end
		if (state_q == ST_DECODE) begin
			k_q      <= '0;
			ok_q     <= 1'b1;
			rdata_q  <= '0;
			refuse_q <= (type_q == cbb_pkg::REQ_WRITE) && !n_le_free;
			addr_q   <= (type_q == cbb_pkg::REQ_WRITE) ? wp_q :
			            (type_q == cbb_pkg::REQ_PEEK)  ? PTR_W'(pwrap) : rp_q;
			case (type_q)
				cbb_pkg::REQ_WRITE: cnt_q <= n_le_free ? n_q : '0;
				cbb_pkg::REQ_READ:  cnt_q <= n_le_used ? n_q : cbb_pkg::COUNT_W'(used_q);
				cbb_pkg::REQ_PEEK:  cnt_q <= n_le_avail ? n_q : cbb_pkg::COUNT_W'(avail_w);
				cbb_pkg::REQ_MATCH: cnt_q <= (n_q != '0 && n_le_used) ? n_q : '0;
				default:            cnt_q <= '0;
			endcase
		end
		if (issue) begin
			addr_q <= addr_adv;
			k_q    <= k_q + cbb_pkg::COUNT_W'(1);
			k_s1   <= k_q[2:0];
		end
		// gather read data in the cycle after each store read
		if (rd_s1) begin
			if (type_q == cbb_pkg::REQ_MATCH) begin
				ok_q <= ok_q & ((pat == cbb_pkg::WILDCARD) || (pat == mem_rdata));
			end else begin
				rdata_q[8*k_s1 +: 8] <= mem_rdata;
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (finish_go) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (finish_go) begin
			read_data  <= rdata_q;
			done_count <= (type_q == cbb_pkg::REQ_WRITE || type_q == cbb_pkg::REQ_READ ||
			               type_q == cbb_pkg::REQ_PEEK) ? cnt_q : '0;
			matched    <= hit;
			used_count <= cbb_pkg::STAT_W'(used_nxt);
			free_count <= cbb_pkg::STAT_W'(size_q - SIZE_W'(1) - SIZE_W'(used_nxt));
			overflow   <= ovf_q | refuse_q;
		end
	end

	assign out_valid    = out_valid_q;
	assign in_ready     = (state_q == ST_IDLE);
	assign stat.busy    = (state_q != ST_IDLE);
	assign stat.ovf     = ovf_q;
	assign stat.rd_pend = rd_s1;

endmodule

// File: rtl/circular_byte_buffer_burst.sv
// Byte ring buffer with burst write, read, peek, flush and match requests.
// An accepted request passes decode, a byte walk over the store and finish; a new request is
// taken only once the last has finished, and the byte-wide single-port store moves one byte a cycle.
// A finished result waits in an output register while the next request is taken.
// Reset: pointers and fill level zero, size 1024 (limited to DEPTH), overflow clear;
// store contents are undefined until written and get no clearing pass.
`timescale 1ns / 1ps

module circular_byte_buffer_burst #(
	parameter int DEPTH = cbb_pkg::DEPTH_DEF,
	parameter int BURST = cbb_pkg::BURST_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_we,
	input  logic [cbb_pkg::CFG_W-1:0] cfg_wdata,
	input  logic                      s_tvalid,
	output logic                      s_tready,
	input  logic [79:0]               s_tdata,   // data_bytes, byte_count, peek_offset, zero pad
	input  logic [2:0]                s_tuser,   // req_type
	output logic                      m_tvalid,
	input  logic                      m_tready,
	output logic [95:0]               m_tdata    // read_data, done_count, matched, used_count,
	                                             // free_count, overflow, zero pad
);

	localparam int PTR_W = $clog2(DEPTH);

	logic [cbb_pkg::DATA_W-1:0]  read_data;
	logic [cbb_pkg::COUNT_W-1:0] done_count;
	logic                        matched;
	logic [cbb_pkg::STAT_W-1:0]  used_count, free_count;
	logic                        overflow;
	cbb_pkg::mem_ctl_t           mem_ctl;
	logic [PTR_W-1:0]            mem_addr;
	logic [7:0]                  mem_wdata, mem_rdata;
	cbb_pkg::stat_t              stat;

	// sequencer
	cbb_ctrl #(
		.DEPTH (DEPTH),
		.BURST (BURST),
		.PTR_W (PTR_W)
	) u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.in_valid   (s_tvalid),
		.in_ready   (s_tready),
		.in_type    (s_tuser),
		.in_data    (s_tdata[63:0]),
		.in_count   (s_tdata[67:64]),
		.in_offset  (s_tdata[77:68]),
		.out_valid  (m_tvalid),
		.out_ready  (m_tready),
		.read_data  (read_data),
		.done_count (done_count),
		.matched    (matched),
		.used_count (used_count),
		.free_count (free_count),
		.overflow   (overflow),
		.mem_ctl    (mem_ctl),
		.mem_addr   (mem_addr),
		.mem_wdata  (mem_wdata),
		.mem_rdata  (mem_rdata),
		.stat       (stat)
	);

	// byte store
	cbb_store #(
		.DEPTH (DEPTH),
		.PTR_W (PTR_W)
	) u_store (
		.clk     (clk),
		.mem_ctl (mem_ctl),
		.addr    (mem_addr),
		.wdata   (mem_wdata),
		.rdata   (mem_rdata)
	);

	// result packing
	assign m_tdata = {6'd0, overflow, free_count, used_count, matched, done_count, read_data};

	// one transaction in flight at a time
	a_single_item: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("request taken while another is in progress");

	// store accessed only while a request is being worked
	a_mem_busy: assert property (@(posedge clk) disable iff (!arst_n)
		mem_ctl.en |-> stat.busy)
		else $error("store access outside a request");

	// every store read is gathered on the next cycle
	a_rd_pend: assert property (@(posedge clk) disable iff (!arst_n)
		mem_ctl.en && !mem_ctl.we |=> stat.rd_pend)
		else $error("store read not followed by data capture");

	// overflow flag is sticky
	a_ovf_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		stat.ovf |=> stat.ovf)
		else $error("overflow flag cleared");

	// byte count never exceeds the burst length
	a_done_burst: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> 32'(done_count) <= 32'(BURST))
		else $error("done count above burst length");

endmodule
